[rtl/krt_pkg.sv]
`timescale 1ns / 1ps

package krt_pkg;

  localparam int KEY_W = 64;
  localparam int IDX_W = 6;
  localparam int CMD_W = 2;
  localparam int STAT_W = 2;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] name;
    logic [KEY_W-1:0] cls;
  } rec_t;

  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctl_t;

endpackage

[rtl/krt_cell.sv]
`timescale 1ns / 1ps

module krt_cell (
  input  logic              clk_i,
  input  krt_pkg::cell_ctl_t ctl_i,
  input  krt_pkg::rec_t     shift_rec_i,
  input  krt_pkg::rec_t     load_rec_i,
  output krt_pkg::rec_t     rec_o
);

  krt_pkg::rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load_en) begin
      rec_d = load_rec_i;
    end else if (ctl_i.shift_en) begin
      rec_d = shift_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

[rtl/keyed_record_table.sv]
`timescale 1ns / 1ps
// Channel   Direction  tdata                                tuser         tlast
// s_axis    in         name_key, class_key                  command       -
// m_axis    out        entry_index, out_name, out_class     status        last
//
// Records sit in a ring of CAPACITY cells; a scan rotates the ring one cell a cycle
// past the compare at cell 0 and stops once it is back in place.
// Add is done from idle; search, remove and list scan the whole ring, then finish.
// A stalled m_axis halts the rotation; s_axis takes a new command only when idle.
// Reset clears the fill count and control; cell contents are not cleared.

module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::DEFAULT_CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // name_key[63:0], class_key[127:64]
  input  logic [1:0]   s_axis_tuser_i,   // command[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // entry_index[5:0], out_name[69:6], out_class[133:70]
  output logic [1:0]   m_axis_tuser_o,   // status[1:0]
  output logic         m_axis_tlast_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1) + 1;
  localparam int IdxW = krt_pkg::IDX_W;
  localparam int KeyW = krt_pkg::KEY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] step_q, step_d;
  krt_pkg::cmd_e cmd_q, cmd_d;
  logic [KeyW-1:0] key_name_q, key_name_d, key_cls_q, key_cls_d;
  logic found_q, found_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;
  krt_pkg::rec_t pend_rec_q, pend_rec_d;
  krt_pkg::rec_t last_rec_q, last_rec_d;

  logic out_valid_q, out_valid_d;
  logic [krt_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [IdxW-1:0] out_idx_q, out_idx_d;
  krt_pkg::rec_t out_rec_q, out_rec_d;
  logic out_last_q, out_last_d;

  krt_pkg::rec_t cell_rec[CAPACITY];
  krt_pkg::rec_t load_rec;
  logic [IW-1:0] load_idx;
  logic load_en, shift_en;

  logic out_free, in_acc, in_range, hit_name, hit_cls, at_last;
  krt_pkg::rec_t head;
  krt_pkg::rec_t in_rec;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_rec.name = s_axis_tdata_i[KeyW-1:0];
  assign in_rec.cls = s_axis_tdata_i[2*KeyW-1:KeyW];

  assign head = cell_rec[0];
  assign in_range = CW'(step_q) < fill_q;
  assign hit_name = in_range && (head.name == key_name_q);
  assign hit_cls = in_range && (head.cls == key_cls_q);
  assign at_last = in_range && (CW'(step_q) + CW'(1) == fill_q);

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    step_d = step_q;
    cmd_d = cmd_q;
    key_name_d = key_name_q;
    key_cls_d = key_cls_q;
    found_d = found_q;
    pend_idx_d = pend_idx_q;
    pend_rec_d = pend_rec_q;
    last_rec_d = last_rec_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_idx_d = out_idx_q;
    out_rec_d = out_rec_q;
    out_last_d = out_last_q;
    load_en = 1'b0;
    load_idx = pend_idx_q;
    load_rec = last_rec_q;
    shift_en = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d = krt_pkg::cmd_e'(s_axis_tuser_i);
          key_name_d = in_rec.name;
          key_cls_d = in_rec.cls;
          found_d = 1'b0;
          step_d = '0;
          if (krt_pkg::cmd_e'(s_axis_tuser_i) == krt_pkg::CMD_ADD) begin
            out_valid_d = 1'b1;
            out_last_d = 1'b1;
            if (fill_q >= CW'(CAPACITY)) begin
              out_status_d = krt_pkg::STAT_FULL;
              out_idx_d = '0;
              out_rec_d = '0;
            end else begin
              load_en = 1'b1;
              load_idx = fill_q[IW-1:0];
              load_rec = in_rec;
              fill_d = fill_q + CW'(1);
              out_status_d = krt_pkg::STAT_OK;
              out_idx_d = IdxW'(fill_q);
              out_rec_d = in_rec;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          shift_en = 1'b1;
          if (cmd_q == krt_pkg::CMD_LIST) begin
            if (hit_cls) begin
              if (found_q) begin
                out_valid_d = 1'b1;
                out_status_d = krt_pkg::STAT_OK;
                out_idx_d = IdxW'(pend_idx_q);
                out_rec_d = pend_rec_q;
                out_last_d = 1'b0;
              end
              found_d = 1'b1;
              pend_idx_d = step_q;
              pend_rec_d = head;
            end
          end else begin
            if (hit_name && !found_q) begin
              found_d = 1'b1;
              pend_idx_d = step_q;
              pend_rec_d = head;
            end
            if (at_last) begin
              last_rec_d = head;
            end
          end
          if (step_q == IW'(CAPACITY - 1)) begin
            state_d = ST_FIN;
          end else begin
            step_d = step_q + IW'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d = 1'b1;
          if (found_q) begin
            out_status_d = krt_pkg::STAT_OK;
            out_idx_d = IdxW'(pend_idx_q);
            out_rec_d = pend_rec_q;
            if (cmd_q == krt_pkg::CMD_REMOVE) begin
              load_en = 1'b1;
              fill_d = fill_q - CW'(1);
            end
          end else begin
            out_status_d = krt_pkg::STAT_NOTFOUND;
            out_idx_d = '0;
            out_rec_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int Nxt = (k + 1) % CAPACITY;
    krt_pkg::cell_ctl_t ctl;
    assign ctl.shift_en = shift_en;
    assign ctl.load_en = load_en && (load_idx == IW'(k));
    krt_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .shift_rec_i(cell_rec[Nxt]),
      .load_rec_i (load_rec),
      .rec_o      (cell_rec[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      step_q <= '0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q <= krt_pkg::CMD_ADD;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      step_q <= step_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_name_q <= key_name_d;
    key_cls_q <= key_cls_d;
    pend_idx_q <= pend_idx_d;
    pend_rec_q <= pend_rec_d;
    last_rec_q <= last_rec_d;
    out_status_q <= out_status_d;
    out_idx_q <= out_idx_d;
    out_rec_q <= out_rec_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = out_status_q;
  assign m_axis_tlast_o = out_last_q;
  assign m_axis_tdata_o = {2'b00, out_rec_q.cls, out_rec_q.name, out_idx_q};

endmodule

[rtl/krt_checker.sv]
`timescale 1ns / 1ps

module krt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o,
  input logic         m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == krt_pkg::STAT_OK ||
      m_axis_tuser_o == krt_pkg::STAT_FULL || m_axis_tuser_o == krt_pkg::STAT_NOTFOUND))
    else $error("unknown status");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != krt_pkg::STAT_OK)
      |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("failed result carries data or is not last");

  a_busy_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("new command taken before list finished");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

[test/keyed_record_table_test.sv]
`timescale 1ns / 1ps

module keyed_record_table_test;

  localparam int CAPACITY = krt_pkg::DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
  localparam int RANDOM_ITEMS = 200;
  localparam int NAME_POOL_N = 12;
  localparam int CLASS_POOL_N = 4;

  typedef struct {
    logic [krt_pkg::STAT_W-1:0] status;
    logic [krt_pkg::IDX_W-1:0]  index;
    logic [krt_pkg::KEY_W-1:0]  name;
    logic [krt_pkg::KEY_W-1:0]  cls;
    logic                       last;
  } table_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = krt_pkg::CMD_ADD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  logic [krt_pkg::KEY_W-1:0] rec_name [CAPACITY];
  logic [krt_pkg::KEY_W-1:0] rec_class [CAPACITY];
  int                        rec_count = 0;
  table_result_t             pending_results [$];

  logic [krt_pkg::KEY_W-1:0] name_pool [NAME_POOL_N];
  logic [krt_pkg::KEY_W-1:0] class_pool [CLASS_POOL_N];

  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int window_left = 0;

  keyed_record_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [krt_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_result(logic [krt_pkg::STAT_W-1:0] status, int index,
                                       logic [krt_pkg::KEY_W-1:0] name,
                                       logic [krt_pkg::KEY_W-1:0] cls,
                                       logic last);
    table_result_t r;
    r.status = status;
    r.index = index[krt_pkg::IDX_W-1:0];
    r.name = name;
    r.cls = cls;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_command(krt_pkg::cmd_e cmd, logic [krt_pkg::KEY_W-1:0] nk,
                                        logic [krt_pkg::KEY_W-1:0] ck);
    int slot;
    int prev;
    slot = -1;
    prev = -1;
    case (cmd)
      krt_pkg::CMD_ADD: begin
        if (rec_count >= CAPACITY) begin
          queue_result(krt_pkg::STAT_FULL, 0, '0, '0, 1'b1);
        end else begin
          rec_name[rec_count] = nk;
          rec_class[rec_count] = ck;
          queue_result(krt_pkg::STAT_OK, rec_count, nk, ck, 1'b1);
          rec_count++;
        end
      end
      krt_pkg::CMD_REMOVE, krt_pkg::CMD_SEARCH: begin
        for (int i = 0; i < rec_count; i++) begin
          if (slot < 0 && rec_name[i] == nk) slot = i;
        end
        if (slot < 0) begin
          queue_result(krt_pkg::STAT_NOTFOUND, 0, '0, '0, 1'b1);
        end else begin
          queue_result(krt_pkg::STAT_OK, slot, rec_name[slot], rec_class[slot], 1'b1);
          if (cmd == krt_pkg::CMD_REMOVE) begin
            rec_name[slot] = rec_name[rec_count-1];
            rec_class[slot] = rec_class[rec_count-1];
            rec_count--;
          end
        end
      end
      default: begin
        // hold each hit back until the next one shows whether it is the final one
        for (int i = 0; i < rec_count; i++) begin
          if (rec_class[i] == ck) begin
            if (prev >= 0)
              queue_result(krt_pkg::STAT_OK, prev, rec_name[prev], rec_class[prev], 1'b0);
            prev = i;
          end
        end
        if (prev < 0) queue_result(krt_pkg::STAT_NOTFOUND, 0, '0, '0, 1'b1);
        else queue_result(krt_pkg::STAT_OK, prev, rec_name[prev], rec_class[prev], 1'b1);
      end
    endcase
  endfunction

  task automatic send_item(krt_pkg::cmd_e cmd, logic [krt_pkg::KEY_W-1:0] nk,
                           logic [krt_pkg::KEY_W-1:0] ck);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {ck, nk};
    s_axis_tuser = cmd;
    do @(posedge clk); while (!s_axis_tready);
    apply_command(cmd, nk, ck);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {rand_key(), rand_key()};
      s_axis_tuser = 2'($urandom_range(3));
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      if (window_left == 0) begin
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        window_left = $urandom_range(16, 96);
      end
      window_left--;
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    logic [krt_pkg::IDX_W-1:0] got_index;
    logic [krt_pkg::KEY_W-1:0] got_name;
    logic [krt_pkg::KEY_W-1:0] got_class;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyed_record_table_test failed");
      $finish;
    end
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got_index = m_axis_tdata[5:0];
      got_name = m_axis_tdata[69:6];
      got_class = m_axis_tdata[133:70];
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status=%0d idx=%0d name=%h class=%h last=%b",
                   m_axis_tuser, got_index, got_name, got_class, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.status !== m_axis_tuser || want.index !== got_index ||
            want.name !== got_name || want.cls !== got_class ||
            want.last !== m_axis_tlast) begin
          if (mismatches < 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  exp: status=%0d idx=%0d name=%h class=%h last=%b",
                     want.status, want.index, want.name, want.cls, want.last);
            $display("  got: status=%0d idx=%0d name=%h class=%h last=%b",
                     m_axis_tuser, got_index, got_name, got_class, m_axis_tlast);
          end
          mismatches++;
        end
      end
    end
  end

  function automatic logic [krt_pkg::KEY_W-1:0] pick_lookup_name();
    int r;
    r = $urandom_range(99);
    if (r < 60 && rec_count > 0) return rec_name[$urandom_range(rec_count-1)];
    if (r < 85) return name_pool[$urandom_range(NAME_POOL_N-1)];
    return rand_key();
  endfunction

  function automatic logic [krt_pkg::KEY_W-1:0] pick_class();
    int r;
    r = $urandom_range(99);
    if (r < 70) return class_pool[$urandom_range(CLASS_POOL_N-1)];
    if (r < 85 && rec_count > 0) return rec_class[$urandom_range(rec_count-1)];
    return rand_key();
  endfunction

  task automatic test_directed();
    logic [krt_pkg::KEY_W-1:0] ones;
    logic [krt_pkg::KEY_W-1:0] alt_a;
    logic [krt_pkg::KEY_W-1:0] alt_c;
    ones = '1;
    alt_a = 64'hAAAA_AAAA_AAAA_AAAA;
    alt_c = 64'h5555_5555_5555_5555;
    send_item(krt_pkg::CMD_LIST, '0, '0);
    send_item(krt_pkg::CMD_SEARCH, '0, ones);
    send_item(krt_pkg::CMD_REMOVE, ones, '0);
    send_item(krt_pkg::CMD_ADD, '0, '0);
    send_item(krt_pkg::CMD_ADD, ones, ones);
    send_item(krt_pkg::CMD_ADD, alt_a, '0);
    send_item(krt_pkg::CMD_ADD, '0, alt_c);
    send_item(krt_pkg::CMD_SEARCH, '0, ones);
    send_item(krt_pkg::CMD_SEARCH, ones, '0);
    send_item(krt_pkg::CMD_SEARCH, alt_c, '0);
    send_item(krt_pkg::CMD_LIST, ones, '0);
    send_item(krt_pkg::CMD_LIST, '0, ones);
    send_item(krt_pkg::CMD_LIST, '0, alt_c);
    send_item(krt_pkg::CMD_LIST, '0, alt_a);
    send_item(krt_pkg::CMD_REMOVE, ones, '0);
    send_item(krt_pkg::CMD_SEARCH, '0, '0);
    send_item(krt_pkg::CMD_REMOVE, '0, ones);
    send_item(krt_pkg::CMD_SEARCH, '0, '0);
    send_item(krt_pkg::CMD_REMOVE, '0, '0);
    send_item(krt_pkg::CMD_REMOVE, alt_a, '0);
    send_item(krt_pkg::CMD_REMOVE, alt_a, '0);
    idle_sender(1);
  endtask

  task automatic test_full_table();
    logic [krt_pkg::KEY_W-1:0] cls;
    cls = class_pool[$urandom_range(CLASS_POOL_N-1)];
    wait_drained();
    // stall the result side so the table backs up its input while adds keep coming
    hold_left = 400;
    while (rec_count < CAPACITY) begin
      send_item(krt_pkg::CMD_ADD, ($urandom_range(1)) ? name_pool[$urandom_range(NAME_POOL_N-1)]
                                                      : rand_key(), cls);
    end
    send_item(krt_pkg::CMD_ADD, rand_key(), rand_key());
    send_item(krt_pkg::CMD_ADD, '1, cls);
    send_item(krt_pkg::CMD_LIST, rand_key(), cls);
    send_item(krt_pkg::CMD_SEARCH, rec_name[CAPACITY-1], rand_key());
    send_item(krt_pkg::CMD_REMOVE, rec_name[CAPACITY-1], rand_key());
    send_item(krt_pkg::CMD_ADD, rand_key(), rand_key());
    send_item(krt_pkg::CMD_ADD, rand_key(), rand_key());
    send_item(krt_pkg::CMD_LIST, rand_key(), cls);
    while (rec_count > 0) begin
      send_item(krt_pkg::CMD_REMOVE, rec_name[$urandom_range(rec_count-1)], rand_key());
      if ($urandom_range(5) == 0) idle_sender($urandom_range(1, 5));
    end
    idle_sender(1);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int burst;
    int r;
    int add_pct;
    krt_pkg::cmd_e cmd;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) wait_drained();
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        add_pct = (rec_count < 8) ? 55 : (rec_count > 56) ? 15 : 35;
        r = $urandom_range(99);
        if (r < add_pct) cmd = krt_pkg::CMD_ADD;
        else if (r < add_pct + (100 - add_pct) * 2 / 5) cmd = krt_pkg::CMD_REMOVE;
        else if (r < add_pct + (100 - add_pct) * 7 / 10) cmd = krt_pkg::CMD_SEARCH;
        else cmd = krt_pkg::CMD_LIST;
        case (cmd)
          krt_pkg::CMD_ADD: send_item(cmd, ($urandom_range(9) < 7) ?
                                      name_pool[$urandom_range(NAME_POOL_N-1)] : rand_key(),
                                      pick_class());
          krt_pkg::CMD_LIST: send_item(cmd, rand_key(), pick_class());
          default: send_item(cmd, pick_lookup_name(), rand_key());
        endcase
        sent++;
      end
      idle_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
    end
    idle_sender(1);
  endtask

  initial begin
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < NAME_POOL_N; i++) name_pool[i] = rand_key();
    class_pool[0] = '1;
    for (int i = 1; i < CLASS_POOL_N; i++) class_pool[i] = rand_key();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_random_traffic(RANDOM_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("keyed_record_table_test passed");
    end else begin
      $display("keyed_record_table_test failed");
    end
    $finish;
  end

endmodule

[keyed_record_table.f]
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table.sv
rtl/krt_checker.sv
test/keyed_record_table_test.sv
